// ===== src/lpht_pkg.sv =====
// shared types and constants of the linear probing hash table
package lpht_pkg;

  // fixed field widths
  localparam int KEY_W    = 24;
  localparam int SLOT_W   = 12;
  localparam int PROBES_W = 13;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // request: one insert or search
  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } lpht_req_t;

  // result of one request
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [PROBES_W-1:0] probes;
  } lpht_res_t;

endpackage

// ===== src/lpht_ram.sv =====
// generic single-write, single-read ram with registered read data
module lpht_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/linear_probe_hash_table.sv =====
// top level: open-addressing hash table with linear probing over one slot ram
//
// channel  ports                      handshake
// -------  -------------------------  ---------------------------------------
// in       start, busy, in_req        taken at an edge with start high, busy low
// out      out_valid, out_res         one-cycle strobe, always taken
//
// a request holds busy through the mul, qmul and reduce states and one probe state
// per slot probed (one per cycle, limited by the single read port of the slot ram);
// the result strobes in the cycle busy drops, so the next request can be taken in
// that same cycle. an insert into a full table ends in the reduce state and probes nothing.
// after reset the slot ram is swept clear, slot by slot, with busy high.
// the result side has no stall: out_valid lasts exactly one cycle.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 4096,
  parameter int KEY_BITS   = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lpht_pkg::lpht_req_t in_req,
  output logic              out_valid,
  output lpht_pkg::lpht_res_t out_res
);
  import lpht_pkg::*;

  // derived widths
  localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int AW  = $clog2(TABLE_SIZE);
  localparam int PW  = $clog2(TABLE_SIZE + 1);
  localparam int SH  = KW + AW;
  localparam int MW  = KW + 2;
  localparam int PRW = KW + MW;
  localparam int DW  = KW + AW + 1;
  localparam longint unsigned RECIP = (64'd1 << SH) / TABLE_SIZE;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_QMUL,
    S_RED,
    S_PROBE
  } state_t;

  state_t          state_r, state_nxt;
  logic            op_r;
  logic [KW-1:0]   key_r;
  logic [PRW-1:0]  prod_r;
  logic [DW-1:0]   qn_r;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [PW-1:0]   probe_r, probe_nxt;
  logic [PW-1:0]   used_cnt_r, used_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  lpht_res_t       out_res_r, out_res_nxt;

  logic [KW-1:0]   quot;
  logic [DW-1:0]   diff;
  logic [DW-1:0]   rem;
  logic [AW-1:0]   idx_inc;
  logic [PW-1:0]   probe_inc;
  logic            ram_we;
  logic [KW:0]     ram_wdata;
  logic [KW:0]     ram_rdata;
  logic            slot_used;
  logic [KW-1:0]   slot_key;

  // slot ram: valid bit on top of the stored key
  lpht_ram #(
    .WIDTH(KW + 1),
    .DEPTH(TABLE_SIZE)
  ) u_slots (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (idx_r),
    .wdata  (ram_wdata),
    .raddr  (idx_nxt),
    .rd_data(ram_rdata)
  );

  assign slot_used = ram_rdata[KW];
  assign slot_key  = ram_rdata[KW-1:0];

  // home slot: key mod table size by reciprocal, one correction step
  assign quot = KW'(prod_r >> SH);
  assign diff = DW'(key_r) - qn_r;
  assign rem  = (diff >= DW'(TABLE_SIZE)) ? (diff - DW'(TABLE_SIZE)) : diff;

  // next probe position with wrap-around
  assign idx_inc   = (idx_r == AW'(TABLE_SIZE - 1)) ? '0 : (idx_r + 1'b1);
  assign probe_inc = probe_r + 1'b1;

  // sequencer next-state logic
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    used_cnt_nxt  = used_cnt_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_wdata     = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (idx_r == AW'(TABLE_SIZE - 1)) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_QMUL;
      end
      S_QMUL: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        idx_nxt   = AW'(rem);
        probe_nxt = '0;
        if (op_r == OP_INSERT && used_cnt_r == PW'(TABLE_SIZE)) begin
          out_valid_nxt      = 1'b1;
          out_res_nxt.status = ST_FULL;
          out_res_nxt.slot   = '0;
          out_res_nxt.probes = '0;
          state_nxt          = S_IDLE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        probe_nxt = probe_inc;
        if (!slot_used) begin
          out_valid_nxt      = 1'b1;
          out_res_nxt.probes = PROBES_W'(probe_inc);
          state_nxt          = S_IDLE;
          if (op_r == OP_INSERT) begin
            ram_we             = 1'b1;
            ram_wdata          = {1'b1, key_r};
            used_cnt_nxt       = used_cnt_r + 1'b1;
            out_res_nxt.status = ST_INSERTED;
            out_res_nxt.slot   = SLOT_W'(idx_r);
          end else begin
            out_res_nxt.status = ST_NOT_FOUND;
            out_res_nxt.slot   = '0;
          end
        end else if (op_r == OP_SEARCH && slot_key == key_r) begin
          out_valid_nxt      = 1'b1;
          out_res_nxt.status = ST_FOUND;
          out_res_nxt.slot   = SLOT_W'(idx_r);
          out_res_nxt.probes = PROBES_W'(probe_inc);
          state_nxt          = S_IDLE;
        end else if (probe_inc == PW'(TABLE_SIZE)) begin
          out_valid_nxt      = 1'b1;
          out_res_nxt.status = ST_FULL;
          out_res_nxt.slot   = '0;
          out_res_nxt.probes = PROBES_W'(probe_inc);
          state_nxt          = S_IDLE;
        end else begin
          idx_nxt = idx_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      used_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_cnt_r  <= used_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    probe_r   <= probe_nxt;
    out_res_r <= out_res_nxt;
  end

  // request capture and hash multiply stages
  always_ff @(posedge clk) begin
    if (start && state_r == S_IDLE) begin
      op_r  <= in_req.op;
      key_r <= KW'(in_req.key);
    end
    prod_r <= PRW'(key_r) * PRW'(MW'(RECIP));
    qn_r   <= DW'(quot) * DW'(TABLE_SIZE);
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  // a result only follows the reduce or probe step
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_RED || $past(state_r) == S_PROBE))
    else $error("result strobe without a finishing step");

  // the fill count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r <= PW'(TABLE_SIZE))
    else $error("used count beyond table size");

  // a successful insert adds exactly one used slot
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.status == ST_INSERTED) |->
      (used_cnt_r == $past(used_cnt_r) + 1'b1))
    else $error("insert did not bump used count");

  // a taken request starts the hash pipeline
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_MUL))
    else $error("request taken but hashing not started");

  // probing never runs past one full cycle of the table
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (probe_r < PW'(TABLE_SIZE)))
    else $error("probe count overran the table");
`endif

endmodule

// ===== tb/tb_linear_probe_hash_table.sv =====
// self-checking testbench for the linear probing hash table: directed and random requests
module tb_linear_probe_hash_table;
  import lpht_pkg::*;

  localparam int SLOTS        = 4096;
  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 12;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  lpht_req_t in_req;
  logic      out_valid;
  lpht_res_t out_res;

  // table image kept by the predictor
  logic [KEY_W-1:0] slot_key [SLOTS];
  bit               slot_taken [SLOTS];
  int unsigned      taken_count;

  lpht_res_t        pending_results[$];
  logic [KEY_W-1:0] stored_keys[$];
  lpht_res_t        expected;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;
  int               burst_left;

  linear_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // probe the table image for one request and update it like the block does
  function automatic lpht_res_t probe_table(input lpht_req_t req);
    lpht_res_t   res;
    int unsigned idx;
    int unsigned count;
    res = '0;
    idx = req.key % SLOTS;
    // insert into a full table examines nothing
    if (req.op == OP_INSERT && taken_count >= SLOTS) begin
      res.status = ST_FULL;
      return res;
    end
    for (count = 1; count <= SLOTS; count++) begin
      if (!slot_taken[idx]) begin
        if (req.op == OP_INSERT) begin
          slot_taken[idx] = 1'b1;
          slot_key[idx]   = req.key;
          taken_count++;
          res.status = ST_INSERTED;
          res.slot   = SLOT_W'(idx);
        end else begin
          res.status = ST_NOT_FOUND;
        end
        res.probes = PROBES_W'(count);
        return res;
      end
      if (req.op == OP_SEARCH && slot_key[idx] == req.key) begin
        res.status = ST_FOUND;
        res.slot   = SLOT_W'(idx);
        res.probes = PROBES_W'(count);
        return res;
      end
      idx = (idx + 1) % SLOTS;
    end
    // whole cycle of used slots without a match
    res.status = ST_FULL;
    res.probes = PROBES_W'(SLOTS);
    return res;
  endfunction

  // bursts of back-to-back requests separated by random gaps
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 40);
    // some bursts follow the last one with no gap at all
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // send one request, wait for it to be taken, record its expected result
  task automatic issue_request(input logic op, input logic [KEY_W-1:0] key);
    lpht_req_t req;
    lpht_res_t res;
    req.op  = op;
    req.key = key;
    pace_sender();
    @(negedge clk);
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    res = probe_table(req);
    pending_results.push_back(res);
    if (op == OP_INSERT && res.status == ST_INSERTED)
      stored_keys.push_back(key);
  endtask

  // extremes of the key and wrap-around from the last slot
  task automatic test_edge_keys();
    issue_request(OP_SEARCH, 24'h000000);
    issue_request(OP_SEARCH, 24'hFFFFFF);
    issue_request(OP_INSERT, 24'h000000);
    issue_request(OP_INSERT, 24'hFFFFFF);
    issue_request(OP_INSERT, 24'hFFFFFF);
    issue_request(OP_SEARCH, 24'hFFFFFF);
    issue_request(OP_SEARCH, 24'h000FFF);
    issue_request(OP_SEARCH, 24'h001000);
    issue_request(OP_INSERT, 24'hFFF000);
    issue_request(OP_SEARCH, 24'hFFF000);
    issue_request(OP_SEARCH, 24'h000000);
  endtask

  // several keys sharing one home slot, duplicates, a miss at the chain end
  task automatic test_collision_chain();
    logic [KEY_W-1:0] chain [6];
    chain = '{24'h001800, 24'hAAA800, 24'h555800, 24'h7FF800, 24'h800800, 24'h123800};
    foreach (chain[i]) issue_request(OP_INSERT, chain[i]);
    foreach (chain[i]) issue_request(OP_SEARCH, chain[i]);
    issue_request(OP_SEARCH, 24'h000800);
    issue_request(OP_INSERT, 24'h555800);
  endtask

  // mixed traffic with hot windows of home slots to grow clusters
  task automatic test_random_mix();
    int unsigned      hot_base;
    int unsigned      home;
    int unsigned      pick;
    logic [KEY_W-1:0] key;
    hot_base = SLOTS - 16;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 300 == 299)
        hot_base = (n % 900 == 899) ? SLOTS - 16 : $urandom_range(0, SLOTS - 1);
      key  = KEY_W'($urandom());
      home = (hot_base + $urandom_range(0, 31)) % SLOTS;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // insert: clustered, duplicate or anywhere
        if (pick < 24)
          key[SLOT_W-1:0] = SLOT_W'(home);
        else if (pick < 32 && stored_keys.size() != 0)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        issue_request(OP_INSERT, key);
      end else begin
        // search: mostly stored keys, some misses inside clusters
        if (pick < 80 && stored_keys.size() != 0)
          key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
        else if (pick < 90)
          key[SLOT_W-1:0] = SLOT_W'(home);
        issue_request(OP_SEARCH, key);
      end
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d probes=%0d",
                 $time, out_res.status, out_res.slot, out_res.probes);
        mismatches++;
      end else begin
        expected = pending_results.pop_front();
        if (out_res.status !== expected.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, expected.status, out_res.status);
          mismatches++;
        end
        if (out_res.slot !== expected.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, expected.slot, out_res.slot);
          mismatches++;
        end
        if (out_res.probes !== expected.probes) begin
          $display("%0t: probes expected %0d actual %0d",
                   $time, expected.probes, out_res.probes);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken and no result
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // test sequence
  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_req       = '0;
    taken_count  = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_keys();
    test_collision_chain();
    test_random_mix();

    // drain outstanding results
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lpht_pkg.sv
src/lpht_ram.sv
src/linear_probe_hash_table.sv
tb/tb_linear_probe_hash_table.sv
